/* rtl/scw_pkg.sv */
// Package for the sector colour wheel: item types, pipeline constants and the
// square-root step used by the radius stages. No dependencies.
package scw_pkg;

    localparam int DEF_COORD_FRAC_BITS = 12;

    // Radius square root: 32-bit radicand, 16-bit root, two result bits per stage
    localparam int RAD_W           = 32;
    localparam int ROOT_W          = 16;
    localparam int REM_W           = ROOT_W + 3;
    localparam int STEPS_PER_STAGE = 2;
    localparam int SQ_STAGES       = ROOT_W / STEPS_PER_STAGE;

    localparam int PROD_W = 36;

    // Lit-channel masks: bit 2 red, bit 1 green, bit 0 blue
    typedef logic [2:0] t_lit;
    localparam t_lit LIT_R  = 3'b100;
    localparam t_lit LIT_RG = 3'b110;
    localparam t_lit LIT_G  = 3'b010;
    localparam t_lit LIT_GB = 3'b011;
    localparam t_lit LIT_B  = 3'b001;
    localparam t_lit LIT_RB = 3'b101;

    typedef struct packed {
        logic signed [15:0] x_coord;
        logic signed [15:0] y_coord;
    } t_in_item;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } t_out_item;

    typedef struct packed {
        logic [RAD_W-1:0]  rad;
        logic [REM_W-1:0]  rem;
        logic [ROOT_W-1:0] root;
        t_lit              lit;
        logic              six;
    } t_sq_stage;

    // One restoring square-root step: bring down two radicand bits, try the next root bit
    function automatic t_sq_stage sq_step(input t_sq_stage s);
        t_sq_stage        r;
        logic [REM_W-1:0] rem_n;
        logic [REM_W-1:0] trial;
        r     = s;
        rem_n = {s.rem[REM_W-3:0], s.rad[RAD_W-1:RAD_W-2]};
        trial = {1'b0, s.root, 2'b01};
        r.rad = {s.rad[RAD_W-3:0], 2'b00};
        if (rem_n >= trial) begin
            r.rem  = rem_n - trial;
            r.root = {s.root[ROOT_W-2:0], 1'b1};
        end else begin
            r.rem  = rem_n;
            r.root = {s.root[ROOT_W-2:0], 1'b0};
        end
        return r;
    endfunction

endpackage

/* rtl/sector_color_wheel_core.sv */
// Sector colour wheel: maps a signed fixed-point plane point to an RGB colour.
// Uses scw_pkg for item types, constants and the square-root step.
//
// One item enters per clock while the input is not stalled and passes through one stage
// of squares and slope products, one stage that sums the squares and picks the
// sector, eight stages of a pipelined square root (two root bits per stage) and
// one output stage that applies the radial shading. Every stage carries a valid
// bit; an empty stage keeps taking items while the output is stalled, so the
// input stalls only once the pipeline is full. wheel_mode should be written
// while no item is in flight.
module sector_color_wheel_core
    import scw_pkg::*;
#(
    parameter int COORD_FRAC_BITS = DEF_COORD_FRAC_BITS
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_cfg_we,
    input  logic      i_cfg_wdata,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_item  i_in_item,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_item
);

    localparam int F  = COORD_FRAC_BITS;
    localparam int CW = (F + 4 > ROOT_W + 2) ? F + 4 : ROOT_W + 2;
    localparam logic [CW-1:0] ONE       = CW'(1) << F;
    localparam logic [CW-1:0] QUARTER   = ONE >> 2;
    localparam logic [CW-1:0] TWO_ONE   = CW'(2) << F;
    localparam logic [CW-1:0] THREE_ONE = CW'(3) << F;
    localparam logic [CW-1:0] FIVE_ONE  = CW'(5) << F;

    typedef struct packed {
        logic signed [PROD_W-1:0] p_yn_big;   // -y * 100000
        logic signed [PROD_W-1:0] p_x_small;  // x * 72654
        logic signed [PROD_W-1:0] p_yn_k;     // -y * 1000
        logic signed [PROD_W-1:0] p_x_steep;  // x * 3077
        logic signed [PROD_W-1:0] p_y_s;      // y * 1732
        logic signed [PROD_W-1:0] p_x_k;      // x * 1000
        logic [RAD_W-1:0]         xx;
        logic [RAD_W-1:0]         yy;
        logic                     y_neg;
        logic                     x_pos;
    } t_a_stage;

    logic r_mode;

    t_a_stage  r_a, n_a;
    t_sq_stage r_b, n_b;
    t_sq_stage r_sq [SQ_STAGES];
    t_sq_stage n_sq [SQ_STAGES];
    t_out_item r_out, n_out;

    logic                 r_vld_a, r_vld_b, r_vld_o;
    logic [SQ_STAGES-1:0] r_vld_sq;
    logic                 en_a, en_b, en_o;
    logic [SQ_STAGES-1:0] en_sq;

    // Stall ripples back only through full stages
    always_comb begin
        en_o                = !r_vld_o || !i_out_stall;
        en_sq[SQ_STAGES-1]  = !r_vld_sq[SQ_STAGES-1] || en_o;
        for (int g = SQ_STAGES - 2; g >= 0; g--) begin
            en_sq[g] = !r_vld_sq[g] || en_sq[g+1];
        end
        en_b = !r_vld_b || en_sq[0];
        en_a = !r_vld_a || en_b;
    end

    assign o_in_stall  = !en_a;
    assign o_out_valid = r_vld_o;
    assign o_out_item  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= 1'b0;
        end else if (i_cfg_we) begin
            r_mode <= i_cfg_wdata;
        end
    end

    // Stage A: squares and slope products
    always_comb begin
        logic signed [16:0] xs;
        logic signed [16:0] ys;
        logic signed [16:0] yn;
        logic signed [31:0] sq_x;
        logic signed [31:0] sq_y;
        xs   = 17'(i_in_item.x_coord);
        ys   = 17'(i_in_item.y_coord);
        yn   = -ys;
        sq_x = 32'(xs) * 32'(xs);
        sq_y = 32'(ys) * 32'(ys);
        n_a.p_yn_big  = PROD_W'(yn) * 36'sd100000;
        n_a.p_x_small = PROD_W'(xs) * 36'sd72654;
        n_a.p_yn_k    = PROD_W'(yn) * 36'sd1000;
        n_a.p_x_steep = PROD_W'(xs) * 36'sd3077;
        n_a.p_y_s     = PROD_W'(ys) * 36'sd1732;
        n_a.p_x_k     = PROD_W'(xs) * 36'sd1000;
        n_a.xx        = RAD_W'(unsigned'(sq_x));
        n_a.yy        = RAD_W'(unsigned'(sq_y));
        n_a.y_neg     = i_in_item.y_coord[15];
        n_a.x_pos     = !i_in_item.x_coord[15] && (i_in_item.x_coord != 16'sd0);
    end

    // Stage B: radicand and sector choice
    always_comb begin
        t_lit lit5;
        t_lit lit6;
        if (r_a.y_neg) begin
            if (r_a.p_yn_big < r_a.p_x_small) begin
                lit5 = LIT_R;
            end else if (r_a.p_yn_k < -r_a.p_x_steep) begin
                lit5 = LIT_G;
            end else begin
                lit5 = LIT_RG;
            end
        end else begin
            if (r_a.p_yn_big > -r_a.p_x_small) begin
                lit5 = LIT_R;
            end else if (r_a.p_yn_k > r_a.p_x_steep) begin
                lit5 = LIT_B;
            end else begin
                lit5 = LIT_RB;
            end
        end
        if (r_a.x_pos) begin
            if (r_a.p_y_s < -r_a.p_x_k) begin
                lit6 = LIT_RB;
            end else if (r_a.p_y_s > r_a.p_x_k) begin
                lit6 = LIT_RG;
            end else begin
                lit6 = LIT_R;
            end
        end else begin
            if (r_a.p_y_s < r_a.p_x_k) begin
                lit6 = LIT_B;
            end else if (r_a.p_y_s > -r_a.p_x_k) begin
                lit6 = LIT_G;
            end else begin
                lit6 = LIT_GB;
            end
        end
        n_b.rad  = r_a.xx + r_a.yy;
        n_b.rem  = '0;
        n_b.root = '0;
        n_b.lit  = r_mode ? lit6 : lit5;
        n_b.six  = r_mode;
    end

    // Square-root stages
    always_comb begin
        for (int g = 0; g < SQ_STAGES; g++) begin
            t_sq_stage t;
            t = (g == 0) ? r_b : r_sq[(g == 0) ? 0 : g - 1];
            for (int k = 0; k < STEPS_PER_STAGE; k++) begin
                t = sq_step(t);
            end
            n_sq[g] = t;
        end
    end

    // Output stage: radial shading
    always_comb begin
        t_sq_stage          last;
        logic [CW-1:0]      rq;
        logic [CW-1:0]      rq4;
        logic [CW-1:0]      k_fade;
        logic [CW-1:0]      k_in;
        logic [CW+7:0]      p_fade;
        logic [CW+7:0]      p_in;
        logic [CW+7:0]      sh_fade;
        logic [CW+7:0]      sh_in;
        logic [7:0]         fade;
        logic [7:0]         inner;
        logic [7:0]         on_v;
        logic [7:0]         off_v;
        last    = r_sq[SQ_STAGES-1];
        rq      = CW'(last.root);
        rq4     = rq << 2;
        k_fade  = TWO_ONE - rq;
        k_in    = THREE_ONE - rq4;
        p_fade  = {k_fade, 8'b0} - {8'b0, k_fade};
        p_in    = {k_in, 8'b0} - {8'b0, k_in};
        sh_fade = p_fade >> (F + 1);
        sh_in   = p_in >> (F + 1);
        fade    = sh_fade[7:0];
        inner   = sh_in[7:0];
        if (!last.six) begin
            on_v  = fade;
            off_v = 8'd0;
        end else if (rq4 < THREE_ONE) begin
            on_v  = 8'd255;
            off_v = inner;
        end else if (rq4 < FIVE_ONE) begin
            on_v  = 8'd255;
            off_v = 8'd0;
        end else begin
            on_v  = fade;
            off_v = 8'd0;
        end
        priority if (rq < QUARTER) begin
            n_out = '{red: 8'd255, green: 8'd255, blue: 8'd255};
        end else if (rq > TWO_ONE) begin
            n_out = '{red: 8'd0, green: 8'd0, blue: 8'd0};
        end else begin
            n_out.red   = last.lit[2] ? on_v : off_v;
            n_out.green = last.lit[1] ? on_v : off_v;
            n_out.blue  = last.lit[0] ? on_v : off_v;
        end
    end

    // Valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld_a  <= 1'b0;
            r_vld_b  <= 1'b0;
            r_vld_sq <= '0;
            r_vld_o  <= 1'b0;
        end else begin
            if (en_a) begin
                r_vld_a <= i_in_valid;
            end
            if (en_b) begin
                r_vld_b <= r_vld_a;
            end
            for (int g = 0; g < SQ_STAGES; g++) begin
                if (en_sq[g]) begin
                    r_vld_sq[g] <= (g == 0) ? r_vld_b : r_vld_sq[(g == 0) ? 0 : g - 1];
                end
            end
            if (en_o) begin
                r_vld_o <= r_vld_sq[SQ_STAGES-1];
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (en_a) begin
            r_a <= n_a;
        end
        if (en_b) begin
            r_b <= n_b;
        end
        for (int g = 0; g < SQ_STAGES; g++) begin
            if (en_sq[g]) begin
                r_sq[g] <= n_sq[g];
            end
        end
        if (en_o) begin
            r_out <= n_out;
        end
    end

`ifndef SYNTH
    // Remainder of a finished square root never exceeds twice the root
    a_sqrt_rem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld_sq[SQ_STAGES-1] |->
            (r_sq[SQ_STAGES-1].rem <= {2'b0, r_sq[SQ_STAGES-1].root, 1'b0}))
        else $error("square-root remainder out of range");

    // Input stalls only when the first stage is occupied
    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> r_vld_a)
        else $error("input stalled with empty first stage");

    // An occupied first stage that cannot move keeps its item
    a_hold_first: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld_a && o_in_stall |=> r_vld_a)
        else $error("item dropped from first stage");

    // Reset empties the output
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");
`endif

endmodule

/* sim/tb_sector_color_wheel_core.sv */
// Testbench for sector_color_wheel_core: directed and random points checked against
// an in-bench colour predictor, with random idling on both sides and an output hold-off.
// Depends on rtl/scw_pkg.sv and rtl/sector_color_wheel_core.sv.
module tb_sector_color_wheel_core
    import scw_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int     FRAC        = DEF_COORD_FRAC_BITS;
    localparam longint ONE         = longint'(1) << FRAC;
    localparam int     DRAIN_WAIT  = 20;
    localparam int     MAX_REPORTS = 10;
    localparam t_lit   LIT_ALL     = 3'b111;
    localparam t_lit   LIT_NONE    = 3'b000;

    logic      i_clk       = 1'b0;
    logic      i_rst_n     = 1'b0;
    logic      i_cfg_we    = 1'b0;
    logic      i_cfg_wdata = 1'b0;
    logic      i_in_valid  = 1'b0;
    logic      o_in_stall;
    t_in_item  i_in_item   = '0;
    logic      o_out_valid;
    logic      i_out_stall = 1'b0;
    t_out_item o_out_item;

    t_out_item expected_colours[$];
    logic      wheel_mode   = 1'b0;
    int        mismatches   = 0;
    int        send_gap_pct = 0;
    int        out_stall_pct = 0;
    int        hold_cycles  = 0;

    sector_color_wheel_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item)
    );

    always #5 i_clk = ~i_clk;

    function automatic longint root_floor(input longint s);
        longint r;
        longint c;
        r = 0;
        for (int b = 16; b >= 0; b--) begin
            c = r + (longint'(1) << b);
            if (c * c <= s) begin
                r = c;
            end
        end
        return r;
    endfunction

    function automatic t_out_item shade(input t_lit lit, input longint on, input longint off);
        t_out_item c;
        c.red   = 8'(lit[2] ? on : off);
        c.green = 8'(lit[1] ? on : off);
        c.blue  = 8'(lit[0] ? on : off);
        return c;
    endfunction

    function automatic t_out_item predict_colour(input t_in_item p, input logic six);
        longint x;
        longint y;
        longint yn;
        longint rq;
        longint fade;
        longint inner;
        t_lit   lit;
        x  = longint'($signed(p.x_coord));
        y  = longint'($signed(p.y_coord));
        rq = root_floor(x * x + y * y);
        if (rq < ONE / 4) begin
            return shade(LIT_ALL, 255, 255);
        end
        if (rq > 2 * ONE) begin
            return shade(LIT_NONE, 0, 0);
        end
        fade = (255 * (2 * ONE - rq)) / (2 * ONE);
        if (!six) begin
            // five-sector wheel works on the mirrored y
            yn = -y;
            if (yn > 0) begin
                if (100000 * yn < 72654 * x) lit = LIT_R;
                else if (1000 * yn < -3077 * x) lit = LIT_G;
                else lit = LIT_RG;
            end else begin
                if (100000 * yn > -72654 * x) lit = LIT_R;
                else if (1000 * yn > 3077 * x) lit = LIT_B;
                else lit = LIT_RB;
            end
            return shade(lit, fade, 0);
        end
        if (x > 0) begin
            if (1732 * y < -1000 * x) lit = LIT_RB;
            else if (1732 * y > 1000 * x) lit = LIT_RG;
            else lit = LIT_R;
        end else begin
            if (1732 * y < 1000 * x) lit = LIT_B;
            else if (1732 * y > -1000 * x) lit = LIT_G;
            else lit = LIT_GB;
        end
        if (4 * rq < 3 * ONE) begin
            inner = (255 * (3 * ONE - 4 * rq)) / (2 * ONE);
            return shade(lit, 255, inner);
        end else if (4 * rq < 5 * ONE) begin
            return shade(lit, 255, 0);
        end
        return shade(lit, fade, 0);
    endfunction

    function automatic t_in_item random_point();
        t_in_item    p;
        int unsigned sel;
        int          k;
        sel = $urandom_range(99);
        k   = $urandom_range(1, 4);
        if (sel < 20) begin
            p.x_coord = 16'($urandom);
            p.y_coord = 16'($urandom);
        end else if (sel < 30) begin
            p.x_coord = 16'(int'($urandom_range(2400)) - 1200);
            p.y_coord = 16'(int'($urandom_range(2400)) - 1200);
        end else if (sel < 35) begin
            // exact slope ties of the five-sector wheel
            p.x_coord = 16'($urandom_range(1) ? 1000 : -1000);
            p.y_coord = 16'($urandom_range(1) ? 3077 : -3077);
        end else if (sel < 40) begin
            // exact slope ties of the six-sector wheel
            p.x_coord = 16'($urandom_range(1) ? 1732 * k : -1732 * k);
            p.y_coord = 16'($urandom_range(1) ? 1000 * k : -1000 * k);
        end else begin
            p.x_coord = 16'(int'($urandom_range(18000)) - 9000);
            p.y_coord = 16'(int'($urandom_range(18000)) - 9000);
        end
        return p;
    endfunction

    // Offer one item and hold it until taken; the expectation is queued on acceptance
    task automatic send_point(input t_in_item p);
        @(negedge i_clk);
        while ($urandom_range(99) < send_gap_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_item  <= p;
        do @(posedge i_clk); while (o_in_stall);
        expected_colours.push_back(predict_colour(p, wheel_mode));
    endtask

    task automatic wait_idle();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (expected_colours.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
    endtask

    task automatic write_wheel_mode(input logic m);
        wait_idle();
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= m;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        wheel_mode   = m;
    endtask

    task automatic test_radius_and_five_sectors();
        write_wheel_mode(1'b0);
        send_point('{16'sd0, 16'sd0});
        send_point('{16'sd1023, 16'sd0});
        send_point('{16'sd1024, 16'sd0});
        send_point('{16'sd8192, 16'sd0});
        send_point('{16'sd8193, 16'sd0});
        send_point('{16'sh8000, 16'sh8000});
        send_point('{16'sh7fff, 16'sh7fff});
        send_point('{16'sd0, 16'sd4096});
        send_point('{16'sd0, -16'sd4096});
        send_point('{-16'sd4096, 16'sd0});
        send_point('{16'sd1000, -16'sd3077});
        send_point('{-16'sd1000, -16'sd3077});
        send_point('{-16'sd1000, 16'sd3077});
        send_point('{16'sd2896, -16'sd2896});
        send_point('{-16'sd2896, 16'sd2896});
    endtask

    task automatic test_six_sector_bands();
        write_wheel_mode(1'b1);
        send_point('{16'sd1732, 16'sd1000});
        send_point('{16'sd1732, -16'sd1000});
        send_point('{-16'sd1732, 16'sd1000});
        send_point('{-16'sd1732, -16'sd1000});
        send_point('{16'sd0, 16'sd4096});
        send_point('{16'sd0, -16'sd4096});
        send_point('{16'sd2000, 16'sd0});
        send_point('{16'sd3072, 16'sd0});
        send_point('{16'sd5120, 16'sd0});
        send_point('{16'sd6000, 16'sd0});
        send_point('{16'sh8000, 16'sh7fff});
    endtask

    task automatic test_random_traffic(input int n, input logic m, input int gap, input int stall);
        write_wheel_mode(m);
        send_gap_pct  = gap;
        out_stall_pct = stall;
        repeat (n) send_point(random_point());
    endtask

    // Hold the output off long enough for the pipeline to fill and stall its input
    task automatic test_output_hold_off();
        write_wheel_mode(1'b1);
        send_gap_pct  = 0;
        out_stall_pct = 0;
        @(posedge i_clk);
        hold_cycles = 80;
        repeat (60) send_point(random_point());
    endtask

    always @(negedge i_clk) begin
        if (hold_cycles > 0) begin
            i_out_stall <= 1'b1;
            hold_cycles  = hold_cycles - 1;
        end else begin
            i_out_stall <= ($urandom_range(99) < out_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_colours.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS) begin
                    $display("unexpected colour %h %h %h", o_out_item.red,
                             o_out_item.green, o_out_item.blue);
                end
            end else begin
                want = expected_colours.pop_front();
                if (o_out_item.red !== want.red || o_out_item.green !== want.green ||
                    o_out_item.blue !== want.blue) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS) begin
                        $display("colour mismatch: expected %h %h %h, got %h %h %h",
                                 want.red, want.green, want.blue, o_out_item.red,
                                 o_out_item.green, o_out_item.blue);
                    end
                end
            end
        end
    end

    initial begin
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_radius_and_five_sectors();
        test_six_sector_bands();
        test_random_traffic(430, 1'b0, 8, 58);
        test_random_traffic(430, 1'b1, 58, 8);
        test_random_traffic(430, 1'b0, 0, 0);
        test_output_hold_off();
        wait_idle();
        if (mismatches == 0 && expected_colours.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("*** FAILED ***");
        $finish;
    end

endmodule
